>>> hw/rtl/tlhf_pkg.sv
`default_nettype none
package tlhf_pkg;

  localparam int unsigned LenW      = 11;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ChunkW    = 13;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [ByteW-1:0] HdrMark     = 8'hF0;
  localparam logic [2:0]       HdrHighMask = 3'h7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHUNK_SIZE = 1'b0,
    CFG_LINK_READY = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_DATA,
    ST_PAD
  } tlhf_state_e;

  typedef struct packed {
    logic              cend;
    logic [ChunkW-1:0] count;
  } chunk_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/tlhf_intf.sv
`default_nettype none
interface tlhf_in_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [tlhf_pkg::LenW-1:0]  packet_length;
  logic [tlhf_pkg::ByteW-1:0] data_byte;

  modport source (output valid, func, packet_length, data_byte, input ready);
  modport sink   (input valid, func, packet_length, data_byte, output ready);
endinterface

interface tlhf_out_if;
  logic                     valid;
  logic                     ready;
  logic [tlhf_pkg::ByteW-1:0] out_byte;
  logic                     chunk_end;
  logic                     packet_end;
  logic                     run_last;

  modport source (output valid, out_byte, chunk_end, packet_end, run_last, input ready);
  modport sink   (input valid, out_byte, chunk_end, packet_end, run_last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tlhf_chunk.sv
`default_nettype none
module tlhf_chunk (
  input  wire logic [tlhf_pkg::ChunkW-1:0] count_i,
  input  wire logic [tlhf_pkg::ChunkW-1:0] size_i,
  input  wire logic                        pkt_end_i,
  output tlhf_pkg::chunk_res_t             res_o
);
  import tlhf_pkg::*;

  logic [ChunkW:0] filled;
  logic [ChunkW:0] limit;

  always_comb begin
    filled     = {1'b0, count_i} + (ChunkW+1)'(1);
    limit      = (size_i == '0) ? (ChunkW+1)'(1 << ChunkW) : {1'b0, size_i};
    res_o.cend = pkt_end_i || (filled >= limit);
    res_o.count = res_o.cend ? '0 : filled[ChunkW-1:0];
  end
endmodule
`default_nettype wire

>>> hw/rtl/tx_length_header_framer.sv
`default_nettype none
// Channel   Dir  Payload                                         Transfer
// in_i      in   func, packet_length, data_byte                  valid & ready
// out_o     out  out_byte, chunk_end, packet_end, run_last       valid & ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i                cfg_we_i
//
// A start item sends the four header bytes and a data item its one byte; the last data
// byte of a short packet is followed by zero pad bytes up to MIN_FRAME. in_i is ready
// only while the sequencer is idle, so a new item is taken only once the last one is
// done. Bytes leave through the shared chunk counter unit and a single output register;
// a stalled out_o holds the sequencer. Reset clears all counters, opens no packet,
// chunk_size 512, link down.
module tx_length_header_framer #(
  parameter int unsigned MIN_FRAME = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tlhf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [tlhf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  tlhf_in_if.sink                             in_i,
  tlhf_out_if.source                          out_o
);
  import tlhf_pkg::*;

  localparam int unsigned PadW = $clog2(MIN_FRAME + 1);
  localparam logic [LenW-1:0] MinLen = LenW'(MIN_FRAME);
  localparam logic [PadW-1:0] PadEnd = PadW'(MIN_FRAME);

  tlhf_state_e       state_q, state_d;
  logic [ChunkW-1:0] chunk_size_q;
  logic              link_ready_q;
  logic [LenW-1:0]   declared_q, declared_d;
  logic [LenW-1:0]   payload_q, payload_d;
  logic [ChunkW-1:0] chunk_cnt_q, chunk_cnt_d;
  logic              active_q, active_d;
  logic [1:0]        hdr_idx_q, hdr_idx_d;
  logic [LenW-1:0]   hdr_len_q, hdr_len_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic              last_q, last_d;
  logic              pad_q, pad_d;
  logic [PadW-1:0]   pad_idx_q, pad_idx_d;

  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q, out_byte_d;
  logic              chunk_end_q, chunk_end_d;
  logic              packet_end_q, packet_end_d;
  logic              run_last_q, run_last_d;

  logic              in_xfer;
  logic              emit;
  logic              pkt_end;
  logic [LenW-1:0]   len_inv;
  logic [LenW-1:0]   pay_inc;
  chunk_res_t        chunk_res;

  tlhf_chunk u_chunk (
    .count_i   (chunk_cnt_q),
    .size_i    (chunk_size_q),
    .pkt_end_i (pkt_end),
    .res_o     (chunk_res)
  );

  assign in_i.ready       = (state_q == ST_IDLE);
  assign in_xfer          = in_i.valid && in_i.ready;
  assign emit             = (state_q != ST_IDLE) && (!out_valid_q || out_o.ready);
  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.chunk_end  = chunk_end_q;
  assign out_o.packet_end = packet_end_q;
  assign out_o.run_last   = run_last_q;

  always_comb begin
    unique case (state_q)
      ST_DATA: pkt_end = last_q && !pad_q;
      ST_PAD:  pkt_end = (pad_idx_q + PadW'(1) == PadEnd);
      default: pkt_end = 1'b0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    declared_d   = declared_q;
    payload_d    = payload_q;
    chunk_cnt_d  = chunk_cnt_q;
    active_d     = active_q;
    hdr_idx_d    = hdr_idx_q;
    hdr_len_d    = hdr_len_q;
    byte_d       = byte_q;
    last_d       = last_q;
    pad_d        = pad_q;
    pad_idx_d    = pad_idx_q;
    out_valid_d  = out_o.ready ? 1'b0 : out_valid_q;
    out_byte_d   = out_byte_q;
    chunk_end_d  = chunk_end_q;
    packet_end_d = packet_end_q;
    run_last_d   = run_last_q;
    len_inv      = ~hdr_len_q;
    pay_inc      = payload_q + LenW'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && link_ready_q) begin
          if (!in_i.func) begin
            if (in_i.packet_length != '0) begin
              active_d    = 1'b1;
              declared_d  = in_i.packet_length;
              hdr_len_d   = in_i.packet_length;
              payload_d   = '0;
              chunk_cnt_d = '0;
              hdr_idx_d   = '0;
              state_d     = ST_HDR;
            end
          end else if (active_q) begin
            byte_d = in_i.data_byte;
            if (pay_inc >= declared_q) begin
              last_d     = 1'b1;
              pad_d      = (declared_q < MinLen);
              pad_idx_d  = declared_q[PadW-1:0];
              active_d   = 1'b0;
              declared_d = '0;
              payload_d  = '0;
            end else begin
              last_d    = 1'b0;
              pad_d     = 1'b0;
              payload_d = pay_inc;
            end
            state_d = ST_DATA;
          end
        end
      end
      ST_HDR: begin
        if (emit) begin
          unique case (hdr_idx_q)
            2'd0:    out_byte_d = hdr_len_q[ByteW-1:0];
            2'd1:    out_byte_d = {5'b0, hdr_len_q[LenW-1:ByteW] & HdrHighMask};
            2'd2:    out_byte_d = len_inv[ByteW-1:0];
            default: out_byte_d = HdrMark | {5'b0, len_inv[LenW-1:ByteW] & HdrHighMask};
          endcase
          run_last_d = (hdr_idx_q == 2'd3);
          hdr_idx_d  = hdr_idx_q + 2'd1;
          if (hdr_idx_q == 2'd3) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (emit) begin
          out_byte_d = byte_q;
          run_last_d = !pad_q;
          state_d    = pad_q ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (emit) begin
          out_byte_d = '0;
          run_last_d = pkt_end;
          pad_idx_d  = pad_idx_q + PadW'(1);
          if (pkt_end) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      out_valid_d  = 1'b1;
      chunk_end_d  = chunk_res.cend;
      packet_end_d = pkt_end;
      chunk_cnt_d  = chunk_res.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= ChunkW'(512);
      link_ready_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CHUNK_SIZE: chunk_size_q <= cfg_wdata_i[ChunkW-1:0];
        CFG_LINK_READY: link_ready_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      declared_q  <= '0;
      payload_q   <= '0;
      chunk_cnt_q <= '0;
      active_q    <= 1'b0;
      hdr_idx_q   <= '0;
      last_q      <= 1'b0;
      pad_q       <= 1'b0;
      pad_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      declared_q  <= declared_d;
      payload_q   <= payload_d;
      chunk_cnt_q <= chunk_cnt_d;
      active_q    <= active_d;
      hdr_idx_q   <= hdr_idx_d;
      last_q      <= last_d;
      pad_q       <= pad_d;
      pad_idx_q   <= pad_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_len_q    <= hdr_len_d;
    byte_q       <= byte_d;
    out_byte_q   <= out_byte_d;
    chunk_end_q  <= chunk_end_d;
    packet_end_q <= packet_end_d;
    run_last_q   <= run_last_d;
  end
endmodule
`default_nettype wire
